FILE: rtl/particle_reflect_absorb_step_core_macros.svh
// assertion macros shared by the rtl
`ifndef PARTICLE_REFLECT_ABSORB_STEP_CORE_MACROS_SVH
`define PARTICLE_REFLECT_ABSORB_STEP_CORE_MACROS_SVH

`ifndef SYNTHESIS

// condition and consequence in the same cycle
`define PRAB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequence in the cycle after the condition
`define PRAB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PRAB_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define PRAB_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/prab_pkg.sv
package prab_pkg;

   localparam int COORD_BITS = 24;
   localparam int FRAC_BITS = 16;
   localparam int DT_BITS = 16;
   localparam int NORM_HI = 14;
   localparam int NORM_LO = 13;
   localparam int CSR_INDEX_BITS = 3;

   localparam int DOMAIN_RADIUS_UNITS = 5;
   localparam int FUEL_RADIUS_UNITS = 1;
   localparam int STEP_DIVISOR = 20;
   localparam int TIME_STEP_RESET = (2 ** DT_BITS + STEP_DIVISOR / 2) / STEP_DIVISOR;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DOMAIN_RADIUS = 3'd0,
      CSR_FUEL_RADIUS   = 3'd1,
      CSR_FUEL_X        = 3'd2,
      CSR_FUEL_Y        = 3'd3,
      CSR_TIME_STEP     = 3'd4
   } prab_csr_type;

   typedef struct packed {
      logic alive;
      logic absorbed;
      logic reflect;
      logic neg_x;
      logic neg_y;
      logic dot_neg;
   } prab_flags_type;

endpackage

FILE: rtl/prab_if.sv
interface prab_req_if #(parameter int COORD_BITS = prab_pkg::COORD_BITS);
   logic valid;
   logic ready;
   logic alive_in;
   logic signed [COORD_BITS-1:0] pos_x;
   logic signed [COORD_BITS-1:0] pos_y;
   logic signed [COORD_BITS-1:0] vel_x;
   logic signed [COORD_BITS-1:0] vel_y;
   modport source (output valid, alive_in, pos_x, pos_y, vel_x, vel_y, input ready);
   modport sink (input valid, alive_in, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface prab_rsp_if #(parameter int COORD_BITS = prab_pkg::COORD_BITS);
   logic valid;
   logic ready;
   logic alive_out;
   logic absorbed;
   logic reflected;
   logic signed [COORD_BITS-1:0] new_pos_x;
   logic signed [COORD_BITS-1:0] new_pos_y;
   logic signed [COORD_BITS-1:0] new_vel_x;
   logic signed [COORD_BITS-1:0] new_vel_y;
   modport source (output valid, alive_out, absorbed, reflected, new_pos_x, new_pos_y,
      new_vel_x, new_vel_y, input ready);
   modport sink (input valid, alive_out, absorbed, reflected, new_pos_x, new_pos_y,
      new_vel_x, new_vel_y, output ready);
endinterface

interface prab_csr_if #(parameter int COORD_BITS = prab_pkg::COORD_BITS);
   logic valid;
   logic ready;
   logic [prab_pkg::CSR_INDEX_BITS-1:0] index;
   logic [COORD_BITS-1:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

FILE: rtl/prab_div.sv
module prab_div #(
   parameter int NUM_BITS = 54,
   parameter int DEN_BITS = 29,
   parameter int QUO_BITS = 28
) (
   input  logic                clock,
   input  logic                en,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   output logic [QUO_BITS-1:0] quo
);

   localparam int CW = DEN_BITS + QUO_BITS;

   logic [NUM_BITS-1:0] rem_ff [QUO_BITS];
   logic [DEN_BITS-1:0] den_ff [QUO_BITS];
   logic [QUO_BITS-1:0] quo_ff [QUO_BITS];

   // restoring division, one quotient bit per stage, msb first
   for (genvar j = 0; j < QUO_BITS; j++) begin : g_step
      logic [NUM_BITS-1:0] rem_prev;
      logic [NUM_BITS-1:0] rem_in;
      logic [DEN_BITS-1:0] den_prev;
      logic [QUO_BITS-1:0] quo_prev;
      logic [QUO_BITS-1:0] quo_in;
      logic [CW-1:0]       trial;
      logic [CW:0]         diff;
      logic                take;

      if (j == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign den_prev = den_ff[j-1];
         assign quo_prev = quo_ff[j-1];
      end

      assign trial  = CW'(den_prev) << (QUO_BITS - 1 - j);
      assign diff   = (CW+1)'(rem_prev) - (CW+1)'(trial);
      assign take   = !diff[CW];
      assign rem_in = take ? NUM_BITS'(diff) : rem_prev;
      assign quo_in = {quo_prev[QUO_BITS-2:0], take};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            den_ff[j] <= den_prev;
            quo_ff[j] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[QUO_BITS-1];

endmodule

FILE: rtl/particle_reflect_absorb_step_core.sv
// Advances one 2D particle per beat by one time step inside a circular domain with an
// absorbing fuel disc; signed fixed point, saturating. One particle is taken every clock
// while the result side is not stalled; its result passes through ten arithmetic stages
// plus a restoring divider that settles one quotient bit per stage for the mirrored
// velocity. A stalled result holds the whole pipeline; nothing is dropped.
// Configuration writes complete at once and should be made while no particle is in flight.
`include "particle_reflect_absorb_step_core_macros.svh"

module particle_reflect_absorb_step_core #(
   parameter int COORD_BITS = prab_pkg::COORD_BITS,
   parameter int FRAC_BITS  = prab_pkg::FRAC_BITS
) (
   input logic        clock,
   input logic        reset,
   prab_req_if.sink   req_chan,
   prab_rsp_if.source rsp_chan,
   prab_csr_if.sink   csr_chan
);

   localparam int CB  = COORD_BITS;
   localparam int RW  = CB - 1;
   localparam int DTW = prab_pkg::DT_BITS;
   localparam int NM  = prab_pkg::NORM_HI;
   localparam int NLO = prab_pkg::NORM_LO;
   localparam int PW  = $clog2(CB);
   localparam int FSW = 2 * CB + 2;
   localparam int DSW = 2 * CB;
   localparam int RSW = 2 * RW;
   localparam int DW  = 2 * NM + 1;
   localparam int AW  = CB + NM + 2;
   localparam int NW  = AW + NM;
   localparam int QW  = NW - 2 * NLO;
   localparam int SW  = CB + 5;
   localparam int NST = QW + 10;

   typedef struct packed {
      logic signed [CB-1:0] pos_x;
      logic signed [CB-1:0] pos_y;
      logic signed [CB-1:0] vel_x;
      logic signed [CB-1:0] vel_y;
   } vec_type;

   function automatic logic signed [CB-1:0] sat_coord(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] hi;
      logic signed [SW-1:0] lo;
      logic signed [CB-1:0] r;
      hi = {6'b000000, {(CB-1){1'b1}}};
      lo = {6'b111111, {(CB-1){1'b0}}};
      if (v > hi) begin
         r = CB'(hi);
      end else if (v < lo) begin
         r = CB'(lo);
      end else begin
         r = CB'(v);
      end
      return r;
   endfunction

   // configuration
   logic [RW-1:0]        domain_radius_ff;
   logic [RW-1:0]        fuel_radius_ff;
   logic signed [CB-1:0] fuel_x_ff;
   logic signed [CB-1:0] fuel_y_ff;
   logic [DTW-1:0]       time_step_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         domain_radius_ff <= RW'(prab_pkg::DOMAIN_RADIUS_UNITS) << FRAC_BITS;
         fuel_radius_ff   <= RW'(prab_pkg::FUEL_RADIUS_UNITS) << FRAC_BITS;
         fuel_x_ff        <= '0;
         fuel_y_ff        <= '0;
         time_step_ff     <= DTW'(prab_pkg::TIME_STEP_RESET);
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (prab_pkg::prab_csr_type'(csr_chan.index))
            prab_pkg::CSR_DOMAIN_RADIUS: domain_radius_ff <= csr_chan.wdata[RW-1:0];
            prab_pkg::CSR_FUEL_RADIUS:   fuel_radius_ff <= csr_chan.wdata[RW-1:0];
            prab_pkg::CSR_FUEL_X:        fuel_x_ff <= csr_chan.wdata;
            prab_pkg::CSR_FUEL_Y:        fuel_y_ff <= csr_chan.wdata;
            prab_pkg::CSR_TIME_STEP:     time_step_ff <= csr_chan.wdata[DTW-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control: one enable for every stage
   logic [NST-1:0] vld_ff;
   logic           en;

   assign en = !vld_ff[NST-1] || rsp_chan.ready;
   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_chan.valid};
      end
   end

   // stage a: offsets and magnitudes
   vec_type              req_vec;
   logic signed [CB:0]   fdx;
   logic signed [CB:0]   fdy;
   logic [CB:0]          fdxm_in;
   logic [CB:0]          fdym_in;
   logic [CB-1:0]        ax_in;
   logic [CB-1:0]        ay_in;

   assign req_vec = '{pos_x: req_chan.pos_x, pos_y: req_chan.pos_y,
                      vel_x: req_chan.vel_x, vel_y: req_chan.vel_y};
   assign fdx     = (CB+1)'(req_chan.pos_x) - (CB+1)'(fuel_x_ff);
   assign fdy     = (CB+1)'(req_chan.pos_y) - (CB+1)'(fuel_y_ff);
   assign fdxm_in = fdx[CB] ? (CB+1)'(-fdx) : (CB+1)'(fdx);
   assign fdym_in = fdy[CB] ? (CB+1)'(-fdy) : (CB+1)'(fdy);
   assign ax_in   = req_chan.pos_x[CB-1] ? CB'(-req_chan.pos_x) : CB'(req_chan.pos_x);
   assign ay_in   = req_chan.pos_y[CB-1] ? CB'(-req_chan.pos_y) : CB'(req_chan.pos_y);

   vec_type       a_vec_ff;
   logic          a_alive_ff;
   logic [CB:0]   a_fdxm_ff;
   logic [CB:0]   a_fdym_ff;
   logic [CB-1:0] a_ax_ff;
   logic [CB-1:0] a_ay_ff;

   // stage b: squares and leading one of the larger magnitude
   logic [FSW-1:0] fsqx_in;
   logic [FSW-1:0] fsqy_in;
   logic [DSW-1:0] dsqx_in;
   logic [DSW-1:0] dsqy_in;
   logic [RSW-1:0] fr2_in;
   logic [RSW-1:0] dr2_in;
   logic [CB-1:0]  mmax;
   logic [PW-1:0]  p_in;

   assign fsqx_in = a_fdxm_ff * a_fdxm_ff;
   assign fsqy_in = a_fdym_ff * a_fdym_ff;
   assign dsqx_in = a_ax_ff * a_ax_ff;
   assign dsqy_in = a_ay_ff * a_ay_ff;
   assign fr2_in  = fuel_radius_ff * fuel_radius_ff;
   assign dr2_in  = domain_radius_ff * domain_radius_ff;
   assign mmax    = (a_ax_ff > a_ay_ff) ? a_ax_ff : a_ay_ff;

   always_comb begin
      p_in = '0;
      for (int i = 0; i < CB; i++) begin
         if (mmax[i]) begin
            p_in = PW'(i);
         end
      end
   end

   vec_type        b_vec_ff;
   logic           b_alive_ff;
   logic [FSW-1:0] b_fsqx_ff;
   logic [FSW-1:0] b_fsqy_ff;
   logic [DSW-1:0] b_dsqx_ff;
   logic [DSW-1:0] b_dsqy_ff;
   logic [RSW-1:0] b_fr2_ff;
   logic [RSW-1:0] b_dr2_ff;
   logic [CB-1:0]  b_ax_ff;
   logic [CB-1:0]  b_ay_ff;
   logic [PW-1:0]  b_p_ff;
   logic           b_mnz_ff;

   // stage c: distance tests and normal reduced to NORM_LO..NORM_HI bits
   logic [FSW:0]             fsum;
   logic [DSW:0]             dsum;
   logic                     absorb;
   logic                     bound;
   logic [NM-1:0]            axn_in;
   logic [NM-1:0]            ayn_in;
   prab_pkg::prab_flags_type c_flags_in;

   assign fsum   = {1'b0, b_fsqx_ff} + {1'b0, b_fsqy_ff};
   assign dsum   = {1'b0, b_dsqx_ff} + {1'b0, b_dsqy_ff};
   assign absorb = fsum <= (FSW+1)'(b_fr2_ff);
   assign bound  = dsum >= (DSW+1)'(b_dr2_ff);

   always_comb begin
      if (b_p_ff > PW'(NLO)) begin
         axn_in = NM'(b_ax_ff >> (b_p_ff - PW'(NLO)));
         ayn_in = NM'(b_ay_ff >> (b_p_ff - PW'(NLO)));
      end else begin
         axn_in = NM'(b_ax_ff << (PW'(NLO) - b_p_ff));
         ayn_in = NM'(b_ay_ff << (PW'(NLO) - b_p_ff));
      end
   end

   always_comb begin
      c_flags_in.alive    = b_alive_ff && !absorb;
      c_flags_in.absorbed = b_alive_ff && absorb;
      // a particle exactly at the origin has no normal and keeps its velocity
      c_flags_in.reflect  = b_alive_ff && !absorb && bound && b_mnz_ff;
      c_flags_in.neg_x    = b_vec_ff.pos_x[CB-1];
      c_flags_in.neg_y    = b_vec_ff.pos_y[CB-1];
      c_flags_in.dot_neg  = 1'b0;
   end

   vec_type                  c_vec_ff;
   prab_pkg::prab_flags_type c_flags_ff;
   logic [NM-1:0]            c_axn_ff;
   logic [NM-1:0]            c_ayn_ff;

   // stage d: velocity by normal products and normal squares
   logic signed [NM:0]    xn;
   logic signed [NM:0]    yn;
   logic signed [CB+NM:0] px_in;
   logic signed [CB+NM:0] py_in;
   logic [2*NM-1:0]       sqx_in;
   logic [2*NM-1:0]       sqy_in;

   assign xn     = c_flags_ff.neg_x ? -$signed({1'b0, c_axn_ff}) : $signed({1'b0, c_axn_ff});
   assign yn     = c_flags_ff.neg_y ? -$signed({1'b0, c_ayn_ff}) : $signed({1'b0, c_ayn_ff});
   assign px_in  = $signed(c_vec_ff.vel_x) * xn;
   assign py_in  = $signed(c_vec_ff.vel_y) * yn;
   assign sqx_in = c_axn_ff * c_axn_ff;
   assign sqy_in = c_ayn_ff * c_ayn_ff;

   vec_type                  d_vec_ff;
   prab_pkg::prab_flags_type d_flags_ff;
   logic [NM-1:0]            d_axn_ff;
   logic [NM-1:0]            d_ayn_ff;
   logic signed [CB+NM:0]    d_px_ff;
   logic signed [CB+NM:0]    d_py_ff;
   logic [2*NM-1:0]          d_sqx_ff;
   logic [2*NM-1:0]          d_sqy_ff;

   // stage e: dot product and squared norm
   logic signed [AW-1:0] dot_in;
   logic [DW-1:0]        n2_in;

   assign dot_in = AW'(d_px_ff) + AW'(d_py_ff);
   assign n2_in  = DW'(d_sqx_ff) + DW'(d_sqy_ff);

   vec_type                  e_vec_ff;
   prab_pkg::prab_flags_type e_flags_ff;
   logic [NM-1:0]            e_axn_ff;
   logic [NM-1:0]            e_ayn_ff;
   logic signed [AW-1:0]     e_dot_ff;
   logic [DW-1:0]            e_n2_ff;

   // stage f: twice the dot magnitude times each normal component
   logic [AW-1:0]            dmag;
   logic [AW-1:0]            dtwice;
   logic [NW-1:0]            mx_in;
   logic [NW-1:0]            my_in;
   prab_pkg::prab_flags_type f_flags_in;

   assign dmag   = e_dot_ff[AW-1] ? AW'(-e_dot_ff) : AW'(e_dot_ff);
   assign dtwice = dmag << 1;
   assign mx_in  = dtwice * e_axn_ff;
   assign my_in  = dtwice * e_ayn_ff;

   always_comb begin
      f_flags_in         = e_flags_ff;
      f_flags_in.dot_neg = e_dot_ff[AW-1];
   end

   vec_type                  f_vec_ff;
   prab_pkg::prab_flags_type f_flags_ff;
   logic [NW-1:0]            f_mx_ff;
   logic [NW-1:0]            f_my_ff;
   logic [DW-1:0]            f_n2_ff;

   // stage g: add half the divisor so the quotient rounds half away from zero
   logic [NW-1:0] numx_in;
   logic [NW-1:0] numy_in;

   assign numx_in = f_mx_ff + NW'(f_n2_ff >> 1);
   assign numy_in = f_my_ff + NW'(f_n2_ff >> 1);

   vec_type                  g_vec_ff;
   prab_pkg::prab_flags_type g_flags_ff;
   logic [NW-1:0]            g_numx_ff;
   logic [NW-1:0]            g_numy_ff;
   logic [DW-1:0]            g_n2_ff;

   // divider stages, with the particle carried alongside
   logic [QW-1:0]            qx;
   logic [QW-1:0]            qy;
   vec_type                  dl_vec_ff [QW];
   prab_pkg::prab_flags_type dl_flags_ff [QW];

   prab_div #(
      .NUM_BITS (NW),
      .DEN_BITS (DW),
      .QUO_BITS (QW)
   ) u_div_x (
      .clock (clock),
      .en    (en),
      .num   (g_numx_ff),
      .den   (g_n2_ff),
      .quo   (qx)
   );

   prab_div #(
      .NUM_BITS (NW),
      .DEN_BITS (DW),
      .QUO_BITS (QW)
   ) u_div_y (
      .clock (clock),
      .en    (en),
      .num   (g_numy_ff),
      .den   (g_n2_ff),
      .quo   (qy)
   );

   // stage h: mirrored velocity
   vec_type                  hv;
   prab_pkg::prab_flags_type hf;
   logic signed [SW-1:0]     sumx;
   logic signed [SW-1:0]     sumy;
   vec_type                  h_vec_in;

   assign hv   = dl_vec_ff[QW-1];
   assign hf   = dl_flags_ff[QW-1];
   assign sumx = (hf.neg_x ^ hf.dot_neg) ?
                 SW'($signed(hv.vel_x)) + $signed(SW'(qx)) :
                 SW'($signed(hv.vel_x)) - $signed(SW'(qx));
   assign sumy = (hf.neg_y ^ hf.dot_neg) ?
                 SW'($signed(hv.vel_y)) + $signed(SW'(qy)) :
                 SW'($signed(hv.vel_y)) - $signed(SW'(qy));

   always_comb begin
      h_vec_in = hv;
      if (hf.reflect) begin
         h_vec_in.vel_x = sat_coord(sumx);
         h_vec_in.vel_y = sat_coord(sumy);
      end
   end

   vec_type                  h_vec_ff;
   prab_pkg::prab_flags_type h_flags_ff;

   // stage i: speed times time step
   logic [CB-1:0]     vmx;
   logic [CB-1:0]     vmy;
   logic [CB+DTW-1:0] mvx_in;
   logic [CB+DTW-1:0] mvy_in;

   assign vmx    = h_vec_ff.vel_x[CB-1] ? CB'(-h_vec_ff.vel_x) : CB'(h_vec_ff.vel_x);
   assign vmy    = h_vec_ff.vel_y[CB-1] ? CB'(-h_vec_ff.vel_y) : CB'(h_vec_ff.vel_y);
   assign mvx_in = vmx * time_step_ff;
   assign mvy_in = vmy * time_step_ff;

   vec_type                  i_vec_ff;
   prab_pkg::prab_flags_type i_flags_ff;
   logic [CB+DTW-1:0]        i_mvx_ff;
   logic [CB+DTW-1:0]        i_mvy_ff;

   // stage j: rounded displacement, new position, dead particles cleared
   logic [CB+DTW:0]      rnd_x;
   logic [CB+DTW:0]      rnd_y;
   logic [CB:0]          stepx;
   logic [CB:0]          stepy;
   logic signed [SW-1:0] npx;
   logic signed [SW-1:0] npy;

   assign rnd_x = {1'b0, i_mvx_ff} + ((CB+DTW+1)'(1) << (DTW - 1));
   assign rnd_y = {1'b0, i_mvy_ff} + ((CB+DTW+1)'(1) << (DTW - 1));
   assign stepx = rnd_x[CB+DTW:DTW];
   assign stepy = rnd_y[CB+DTW:DTW];
   assign npx   = i_vec_ff.vel_x[CB-1] ?
                  SW'($signed(i_vec_ff.pos_x)) - $signed(SW'(stepx)) :
                  SW'($signed(i_vec_ff.pos_x)) + $signed(SW'(stepx));
   assign npy   = i_vec_ff.vel_y[CB-1] ?
                  SW'($signed(i_vec_ff.pos_y)) - $signed(SW'(stepy)) :
                  SW'($signed(i_vec_ff.pos_y)) + $signed(SW'(stepy));

   vec_type j_vec_in;

   always_comb begin
      j_vec_in = '0;
      if (i_flags_ff.alive) begin
         j_vec_in.pos_x = sat_coord(npx);
         j_vec_in.pos_y = sat_coord(npy);
         j_vec_in.vel_x = i_vec_ff.vel_x;
         j_vec_in.vel_y = i_vec_ff.vel_y;
      end
   end

   vec_type j_vec_ff;
   logic    j_alive_ff;
   logic    j_absorbed_ff;
   logic    j_reflected_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a_vec_ff   <= req_vec;
         a_alive_ff <= req_chan.alive_in;
         a_fdxm_ff  <= fdxm_in;
         a_fdym_ff  <= fdym_in;
         a_ax_ff    <= ax_in;
         a_ay_ff    <= ay_in;

         b_vec_ff   <= a_vec_ff;
         b_alive_ff <= a_alive_ff;
         b_fsqx_ff  <= fsqx_in;
         b_fsqy_ff  <= fsqy_in;
         b_dsqx_ff  <= dsqx_in;
         b_dsqy_ff  <= dsqy_in;
         b_fr2_ff   <= fr2_in;
         b_dr2_ff   <= dr2_in;
         b_ax_ff    <= a_ax_ff;
         b_ay_ff    <= a_ay_ff;
         b_p_ff     <= p_in;
         b_mnz_ff   <= mmax != '0;

         c_vec_ff   <= b_vec_ff;
         c_flags_ff <= c_flags_in;
         c_axn_ff   <= axn_in;
         c_ayn_ff   <= ayn_in;

         d_vec_ff   <= c_vec_ff;
         d_flags_ff <= c_flags_ff;
         d_axn_ff   <= c_axn_ff;
         d_ayn_ff   <= c_ayn_ff;
         d_px_ff    <= px_in;
         d_py_ff    <= py_in;
         d_sqx_ff   <= sqx_in;
         d_sqy_ff   <= sqy_in;

         e_vec_ff   <= d_vec_ff;
         e_flags_ff <= d_flags_ff;
         e_axn_ff   <= d_axn_ff;
         e_ayn_ff   <= d_ayn_ff;
         e_dot_ff   <= dot_in;
         e_n2_ff    <= n2_in;

         f_vec_ff   <= e_vec_ff;
         f_flags_ff <= f_flags_in;
         f_mx_ff    <= mx_in;
         f_my_ff    <= my_in;
         f_n2_ff    <= e_n2_ff;

         g_vec_ff   <= f_vec_ff;
         g_flags_ff <= f_flags_ff;
         g_numx_ff  <= numx_in;
         g_numy_ff  <= numy_in;
         g_n2_ff    <= f_n2_ff;

         dl_vec_ff[0]   <= g_vec_ff;
         dl_flags_ff[0] <= g_flags_ff;
         for (int k = 1; k < QW; k++) begin
            dl_vec_ff[k]   <= dl_vec_ff[k-1];
            dl_flags_ff[k] <= dl_flags_ff[k-1];
         end

         h_vec_ff   <= h_vec_in;
         h_flags_ff <= hf;

         i_vec_ff   <= h_vec_ff;
         i_flags_ff <= h_flags_ff;
         i_mvx_ff   <= mvx_in;
         i_mvy_ff   <= mvy_in;

         j_vec_ff       <= j_vec_in;
         j_alive_ff     <= i_flags_ff.alive;
         j_absorbed_ff  <= i_flags_ff.absorbed;
         j_reflected_ff <= i_flags_ff.reflect;
      end
   end

   assign rsp_chan.valid     = vld_ff[NST-1];
   assign rsp_chan.alive_out = j_alive_ff;
   assign rsp_chan.absorbed  = j_absorbed_ff;
   assign rsp_chan.reflected = j_reflected_ff;
   assign rsp_chan.new_pos_x = j_vec_ff.pos_x;
   assign rsp_chan.new_pos_y = j_vec_ff.pos_y;
   assign rsp_chan.new_vel_x = j_vec_ff.vel_x;
   assign rsp_chan.new_vel_y = j_vec_ff.vel_y;

   `PRAB_ASSERT_SAME(a_absorbed_dead, clock, reset, rsp_chan.valid && rsp_chan.absorbed, !rsp_chan.alive_out && !rsp_chan.reflected, "absorbed beat marked live or reflected")
   `PRAB_ASSERT_SAME(a_reflect_live, clock, reset, rsp_chan.valid && rsp_chan.reflected, rsp_chan.alive_out, "reflected beat not live")
   `PRAB_ASSERT_SAME(a_dead_zero, clock, reset, rsp_chan.valid && !rsp_chan.alive_out, rsp_chan.new_pos_x == '0 && rsp_chan.new_pos_y == '0 && rsp_chan.new_vel_x == '0 && rsp_chan.new_vel_y == '0, "dead beat carries nonzero state")
   `PRAB_ASSERT_SAME(a_stall_blocks_input, clock, reset, rsp_chan.valid && !rsp_chan.ready, !req_chan.ready, "input taken while pipeline stalled")
   `PRAB_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_chan.valid, "result valid straight after reset")

endmodule

FILE: tb/particle_reflect_absorb_step_core_tb.sv
module particle_reflect_absorb_step_core_tb;

   localparam int CB = prab_pkg::COORD_BITS;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      bit alive;
      logic signed [CB-1:0] px;
      logic signed [CB-1:0] py;
      logic signed [CB-1:0] vx;
      logic signed [CB-1:0] vy;
   } particle_type;

   typedef struct {
      bit alive;
      bit absorbed;
      bit reflected;
      logic signed [CB-1:0] px;
      logic signed [CB-1:0] py;
      logic signed [CB-1:0] vx;
      logic signed [CB-1:0] vy;
   } step_result_type;

   logic clock;
   logic reset;
   int   fail_count;
   bit   rsp_busy_mode;
   bit   req_gap_mode;

   // predictor copy of the registers
   longint dom_r;
   longint fuel_r;
   longint fuel_cx;
   longint fuel_cy;
   longint dt;

   step_result_type expected_steps[$];

   prab_req_if req_chan();
   prab_rsp_if rsp_chan();
   prab_csr_if csr_chan();

   particle_reflect_absorb_step_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clamp_coord(longint v);
      longint hi;
      hi = (longint'(1) << (CB - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic longint abs_l(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint advance(longint p, longint v);
      longint d;
      d = (abs_l(v) * dt + (longint'(1) << (prab_pkg::DT_BITS - 1))) >>> prab_pkg::DT_BITS;
      return clamp_coord(v < 0 ? p - d : p + d);
   endfunction

   function automatic longint mirror_comp(longint v, longint dot, longint c, longint n2);
      longint q;
      q = (2 * abs_l(dot) * abs_l(c) + (n2 >>> 1)) / n2;
      return clamp_coord(((dot < 0) != (c < 0)) ? v + q : v - q);
   endfunction

   function automatic step_result_type predict_step(particle_type p);
      step_result_type r;
      longint x, y, vx, vy, dx, dy, ax, ay, m, xn, yn, n2, dot;
      x = p.px; y = p.py; vx = p.vx; vy = p.vy;
      r = '{default: '0};
      if (!p.alive) return r;
      dx = x - fuel_cx;
      dy = y - fuel_cy;
      if (dx * dx + dy * dy <= fuel_r * fuel_r) begin
         r.absorbed = 1'b1;
         return r;
      end
      if (x * x + y * y >= dom_r * dom_r) begin
         ax = abs_l(x);
         ay = abs_l(y);
         m = ax > ay ? ax : ay;
         if (m != 0) begin
            while (m >= (longint'(1) << prab_pkg::NORM_HI)) begin
               ax = ax >>> 1; ay = ay >>> 1; m = m >>> 1;
            end
            while (m < (longint'(1) << prab_pkg::NORM_LO)) begin
               ax = ax << 1; ay = ay << 1; m = m << 1;
            end
            xn = x < 0 ? -ax : ax;
            yn = y < 0 ? -ay : ay;
            n2 = ax * ax + ay * ay;
            dot = vx * xn + vy * yn;
            vx = mirror_comp(vx, dot, xn, n2);
            vy = mirror_comp(vy, dot, yn, n2);
            r.reflected = 1'b1;
         end
      end
      r.alive = 1'b1;
      r.px = CB'(advance(x, vx));
      r.py = CB'(advance(y, vy));
      r.vx = CB'(vx);
      r.vy = CB'(vy);
      return r;
   endfunction

   function automatic int rand_gap();
      int sel;
      sel = $urandom_range(99);
      if (sel < 65) return 0;
      if (sel < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 5);
   endfunction

   // result side: stall pattern changes at the falling edge
   int stall_left;
   always @(negedge clock) begin
      if (!rsp_busy_mode) begin
         rsp_chan.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if ($urandom_range(3) == 0) begin
         stall_left <= rand_gap();
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v !== act_v) begin
         $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      step_result_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_steps.size() == 0) begin
            $display("%0t unexpected result beat", $time);
            fail_count++;
         end else begin
            e = expected_steps.pop_front();
            check_field("alive_out", e.alive, rsp_chan.alive_out);
            check_field("absorbed", e.absorbed, rsp_chan.absorbed);
            check_field("reflected", e.reflected, rsp_chan.reflected);
            check_field("new_pos_x", e.px, rsp_chan.new_pos_x);
            check_field("new_pos_y", e.py, rsp_chan.new_pos_y);
            check_field("new_vel_x", e.vx, rsp_chan.new_vel_x);
            check_field("new_vel_y", e.vy, rsp_chan.new_vel_y);
         end
      end
   end

   task automatic queue_expected(step_result_type r);
      expected_steps = {expected_steps, r};
   endtask

   task automatic send_particle(particle_type p);
      int gap;
      gap = req_gap_mode ? rand_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid    = 1'b1;
      req_chan.alive_in = p.alive;
      req_chan.pos_x    = p.px;
      req_chan.pos_y    = p.py;
      req_chan.vel_x    = p.vx;
      req_chan.vel_y    = p.vy;
      do @(posedge clock); while (!req_chan.ready);
      queue_expected(predict_step(p));
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (expected_steps.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(prab_pkg::prab_csr_type idx, logic [CB-1:0] val);
      @(negedge clock);
      csr_chan.valid = 1'b1;
      csr_chan.index = idx;
      csr_chan.wdata = val;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid = 1'b0;
      case (idx)
         prab_pkg::CSR_DOMAIN_RADIUS: dom_r = val[CB-2:0];
         prab_pkg::CSR_FUEL_RADIUS:   fuel_r = val[CB-2:0];
         prab_pkg::CSR_FUEL_X:        fuel_cx = longint'(signed'(val));
         prab_pkg::CSR_FUEL_Y:        fuel_cy = longint'(signed'(val));
         prab_pkg::CSR_TIME_STEP:     dt = val[prab_pkg::DT_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(longint dr, longint fr, longint fx, longint fy, longint ts);
      write_csr(prab_pkg::CSR_DOMAIN_RADIUS, dr[CB-1:0]);
      write_csr(prab_pkg::CSR_FUEL_RADIUS, fr[CB-1:0]);
      write_csr(prab_pkg::CSR_FUEL_X, fx[CB-1:0]);
      write_csr(prab_pkg::CSR_FUEL_Y, fy[CB-1:0]);
      write_csr(prab_pkg::CSR_TIME_STEP, ts[CB-1:0]);
   endtask

   function automatic particle_type make_particle(bit alive, longint x, longint y,
                                                  longint vx, longint vy);
      particle_type p;
      p.alive = alive;
      p.px = CB'(clamp_coord(x));
      p.py = CB'(clamp_coord(y));
      p.vx = CB'(clamp_coord(vx));
      p.vy = CB'(clamp_coord(vy));
      return p;
   endfunction

   function automatic longint rand_full();
      logic signed [CB-1:0] v;
      v = CB'($urandom());
      return v;
   endfunction

   function automatic longint rand_around(longint span);
      longint s;
      s = span < 16 ? 16 : span;
      if (s > 64'h7FFFFFFF) s = 64'h7FFFFFFF;
      return longint'($urandom_range(32'(2 * s))) - s;
   endfunction

   function automatic particle_type rand_particle();
      int sel;
      longint x, y, vx, vy;
      sel = $urandom_range(99);
      if ($urandom_range(3) == 0) begin
         vx = rand_full(); vy = rand_full();
      end else begin
         vx = rand_around(1 << 18); vy = rand_around(1 << 18);
      end
      if (sel < 8) begin
         x = rand_full(); y = rand_full();
         return make_particle(1'b0, x, y, vx, vy);
      end else if (sel < 40) begin
         // around the domain edge
         x = rand_around(dom_r + dom_r / 4 + 8);
         y = rand_around(dom_r + dom_r / 4 + 8);
      end else if (sel < 60) begin
         // around the fuel disc edge
         x = fuel_cx + rand_around(fuel_r + fuel_r / 4 + 8);
         y = fuel_cy + rand_around(fuel_r + fuel_r / 4 + 8);
      end else if (sel < 75) begin
         // on an axis at the domain radius, the other coordinate near zero
         x = (sel & 1) ? dom_r : -dom_r;
         y = rand_around(4);
         if (sel & 2) begin
            y = x; x = rand_around(4);
         end
      end else begin
         x = rand_full(); y = rand_full();
      end
      return make_particle(1'b1, x, y, vx, vy);
   endfunction

   task automatic run_random(int count);
      repeat (count) send_particle(rand_particle());
   endtask

   task automatic test_directed();
      longint mx;
      mx = (longint'(1) << (CB - 1)) - 1;
      send_particle(make_particle(1'b0, 100, 200, 300, 400));
      send_particle(make_particle(1'b0, -mx - 1, mx, mx, -mx - 1));
      send_particle(make_particle(1'b1, 0, 0, 1000, 1000));
      send_particle(make_particle(1'b1, fuel_r, 0, 5, 5));
      send_particle(make_particle(1'b1, fuel_r + 1, 0, 5, 5));
      send_particle(make_particle(1'b1, 0, -fuel_r - 1, -70000, 3));
      send_particle(make_particle(1'b1, 2 << 16, 1 << 16, 1 << 16, -(1 << 16)));
      send_particle(make_particle(1'b1, dom_r - 1, 0, 1 << 16, 0));
      send_particle(make_particle(1'b1, dom_r, 0, 1 << 16, 1 << 15));
      send_particle(make_particle(1'b1, 0, -dom_r, 3 << 16, -(2 << 16)));
      send_particle(make_particle(1'b1, 4 << 16, 4 << 16, 1 << 16, 1 << 16));
      send_particle(make_particle(1'b1, mx, mx, mx, mx));
      send_particle(make_particle(1'b1, -mx - 1, -mx - 1, -mx - 1, -mx - 1));
      send_particle(make_particle(1'b1, mx, -mx - 1, -mx - 1, mx));
      send_particle(make_particle(1'b1, mx - 10, 0, -mx - 1, 0));
      send_particle(make_particle(1'b1, 3 << 16, 0, mx, 0));
      send_particle(make_particle(1'b1, 3 << 16, 0, -1, 1));
      send_particle(make_particle(1'b1, -mx + 5, 2, 0, -mx - 1));
      wait_drain();
   endtask

   task automatic test_default_random();
      run_random(300);
      // hold the sender until the pipeline has fully emptied
      wait_drain();
      rsp_busy_mode = 1'b0;
      req_gap_mode = 1'b0;
      run_random(150);
      rsp_busy_mode = 1'b1;
      req_gap_mode = 1'b1;
      run_random(150);
      wait_drain();
   endtask

   task automatic test_config_sweep();
      longint mx;
      mx = (longint'(1) << (CB - 1)) - 1;
      // zero domain radius: origin has no normal
      set_config(0, 100, 5 << 16, -(3 << 16), 65535);
      send_particle(make_particle(1'b1, 0, 0, 12345, -54321));
      send_particle(make_particle(1'b1, 0, 0, -mx - 1, mx));
      run_random(100);
      wait_drain();
      set_config(mx, 0, -mx - 1, mx, 0);
      send_particle(make_particle(1'b1, -mx - 1, mx, 7, 7));
      run_random(100);
      wait_drain();
      set_config(mx, mx, 0, 0, 1);
      run_random(60);
      wait_drain();
      set_config(100 << 16, 30 << 16, mx, -mx - 1, 65535);
      run_random(100);
      wait_drain();
      set_config(1, 1, -1, 1, 32768);
      send_particle(make_particle(1'b1, 0, 0, 3, 3));
      run_random(100);
      wait_drain();
      set_config(2 << 16, 1 << 14, 1 << 16, 1 << 16, 20000);
      run_random(100);
      wait_drain();
      set_config(327680, 65536, 0, 0, 3277);
      run_random(60);
      wait_drain();
   endtask

   initial begin
      #20000000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      fail_count = 0;
      rsp_busy_mode = 1'b1;
      req_gap_mode = 1'b1;
      stall_left = 0;
      req_chan.valid = 1'b0;
      req_chan.alive_in = 1'b0;
      req_chan.pos_x = '0;
      req_chan.pos_y = '0;
      req_chan.vel_x = '0;
      req_chan.vel_y = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = prab_pkg::CSR_DOMAIN_RADIUS;
      csr_chan.wdata = '0;
      dom_r = 327680;
      fuel_r = 65536;
      fuel_cx = 0;
      fuel_cy = 0;
      dt = prab_pkg::TIME_STEP_RESET;
      repeat (6) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_default_random();
      test_config_sweep();
      wait_drain();
      if (fail_count == 0 && expected_steps.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/prab_pkg.sv
rtl/prab_if.sv
rtl/prab_div.sv
rtl/particle_reflect_absorb_step_core.sv
tb/particle_reflect_absorb_step_core_tb.sv
